// ===== sv/bmg_pkg.sv =====
`timescale 1ns / 1ps
package bmg_pkg;

  // Input and fixed-point formats
  localparam int UNIFORM_BITS = 32;
  localparam int R_FRAC       = 28;
  localparam int TRIG_FRAC    = 30;
  localparam int Z_FRAC       = 24;

  // Pipeline depths
  localparam int LOG_STEPS  = 30;
  localparam int SQRT_STEPS = 32;
  localparam int TERMS      = 6;
  localparam int LOG_LAT    = LOG_STEPS + 4;
  localparam int SQRT_LAT   = SQRT_STEPS;
  localparam int TRIG_LAT   = 3 * TERMS + 3;
  localparam int SCALE_LAT  = 3;
  localparam int TRIG_DELAY = LOG_LAT + SQRT_LAT - TRIG_LAT;
  localparam int TOTAL_LAT  = LOG_LAT + SQRT_LAT + SCALE_LAT;

  // Constants
  localparam logic [27:0] LN2_Q28 = 28'd186065279;
  localparam logic [29:0] PI4_Q30 = 30'd843314857;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  typedef enum logic [1:0] {
    REG_MEAN      = 2'd0,
    REG_STD_DEV   = 2'd1,
    REG_TOLERANCE = 2'd2
  } reg_index_t;

  // Signed trig value as sign and Q.30 magnitude
  typedef struct packed {
    logic        neg;
    logic [30:0] mag;
  } trig_t;

endpackage

// ===== sv/bmg_log.sv =====
`timescale 1ns / 1ps
module bmg_log import bmg_pkg::*; (
  input  logic        clk,
  input  logic [31:0] u,
  output logic [35:0] neg2ln
);

  logic [4:0]           lz;
  logic [31:0]          u_norm;
  logic [5:0]           ipart;
  logic [30:0]          m_pipe  [0:LOG_STEPS];
  logic [LOG_STEPS-1:0] f_pipe  [0:LOG_STEPS];
  logic [5:0]           ip_pipe [0:LOG_STEPS];
  logic [35:0]          neglog;
  logic [45:0]          pp_lo;
  logic [45:0]          pp_hi;
  logic [63:0]          scaled;

  // Find the leading one and normalize to Q1.30
  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (u[i]) lz = 5'(31 - i);
    end
    u_norm = u << lz;
    ipart  = 6'(UNIFORM_BITS - 31) + 6'(lz);
  end

  always_ff @(posedge clk) begin
    m_pipe[0]  <= u_norm[31:1];
    f_pipe[0]  <= '0;
    ip_pipe[0] <= ipart;
  end

  // One fraction bit of log2 per stage by squaring
  for (genvar j = 0; j < LOG_STEPS; j++) begin : g_sq
    logic [61:0]          sq;
    logic [31:0]          sq_hi;
    logic [LOG_STEPS-1:0] f_set;
    assign sq    = 62'(m_pipe[j]) * 62'(m_pipe[j]);
    assign sq_hi = sq[61:30];
    always_comb begin
      f_set = f_pipe[j];
      f_set[LOG_STEPS-1-j] = 1'b1;
    end
    always_ff @(posedge clk) begin
      ip_pipe[j+1] <= ip_pipe[j];
      if (sq_hi[31]) begin
        m_pipe[j+1] <= sq_hi[31:1];
        f_pipe[j+1] <= f_set;
      end else begin
        m_pipe[j+1] <= sq_hi[30:0];
        f_pipe[j+1] <= f_pipe[j];
      end
    end
  end

  // Scale -log2 u by 2 ln 2 in two partial products, round to Q.30
  assign scaled = {pp_hi, 18'd0} + 64'(pp_lo) + (64'd1 << 26);

  always_ff @(posedge clk) begin
    neglog <= {ip_pipe[LOG_STEPS], 30'd0} - 36'(f_pipe[LOG_STEPS]);
    pp_lo  <= 46'(neglog[17:0]) * 46'(LN2_Q28);
    pp_hi  <= 46'(neglog[35:18]) * 46'(LN2_Q28);
    neg2ln <= scaled[62:27];
  end

endmodule

// ===== sv/bmg_sqrt.sv =====
`timescale 1ns / 1ps
module bmg_sqrt import bmg_pkg::*; (
  input  logic        clk,
  input  logic [35:0] x_in,
  output logic [30:0] r
);

  logic [63:0] rem_pipe [1:SQRT_STEPS];
  logic [63:0] res_pipe [1:SQRT_STEPS];

  // One result bit per stage, restoring form
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] rem_cur;
    logic [63:0] res_cur;
    logic [63:0] trial;
    if (j == 0) begin : g_first
      assign rem_cur = {2'b00, x_in, 26'd0};
      assign res_cur = '0;
    end else begin : g_rest
      assign rem_cur = rem_pipe[j];
      assign res_cur = res_pipe[j];
    end
    assign trial = res_cur + BIT;
    always_ff @(posedge clk) begin
      if (rem_cur >= trial) begin
        rem_pipe[j+1] <= rem_cur - trial;
        res_pipe[j+1] <= (res_cur >> 1) + BIT;
      end else begin
        rem_pipe[j+1] <= rem_cur;
        res_pipe[j+1] <= res_cur >> 1;
      end
    end
  end

  assign r = res_pipe[SQRT_STEPS][30:0];

endmodule

// ===== sv/bmg_trig.sv =====
`timescale 1ns / 1ps
module bmg_trig import bmg_pkg::*; (
  input  logic        clk,
  input  logic [31:0] v,
  output trig_t       cos_out,
  output trig_t       sin_out
);

  logic [29:0]        f_adj;
  logic [59:0]        theta_prod;
  logic [29:0]        theta1;
  logic [2:0]         oct1;
  logic [59:0]        x2_prod;
  logic [30:0]        t_b  [0:1][0:TERMS];
  logic signed [32:0] a_b  [0:1][0:TERMS];
  logic [29:0]        x2_b [0:TERMS];
  logic [2:0]         oct_b [0:TERMS];
  logic [30:0]        s_cl;
  logic [30:0]        c_cl;
  logic [30:0]        sa;
  logic [30:0]        ca;
  trig_t              cos_next;
  trig_t              sin_next;

  function automatic logic [30:0] clamp_q30(input logic signed [32:0] a);
    logic [30:0] res;
    if (a < 33'sd0) res = '0;
    else if (a > $signed({2'b00, Q30_ONE})) res = Q30_ONE;
    else res = a[30:0];
    return res;
  endfunction

  // Fold the phase into an octant and scale to radians
  assign f_adj      = v[29] ? ((30'd1 << 29) - 30'(v[28:0])) : 30'(v[28:0]);
  assign theta_prod = 60'(f_adj) * 60'(PI4_Q30);
  assign x2_prod    = 60'(theta1) * 60'(theta1);

  always_ff @(posedge clk) begin
    theta1    <= theta_prod[58:29];
    oct1      <= v[31:29];
    x2_b[0]   <= x2_prod[59:30];
    oct_b[0]  <= oct1;
    t_b[0][0] <= 31'(theta1);
    a_b[0][0] <= $signed(33'(theta1));
    t_b[1][0] <= Q30_ONE;
    a_b[1][0] <= $signed({2'b00, Q30_ONE});
  end

  // Taylor terms: multiply, reciprocal estimate, correct and accumulate
  for (genvar k = 0; k < TERMS; k++) begin : g_term
    logic [29:0] x2_s1;
    logic [29:0] x2_s2;
    logic [2:0]  oct_s1;
    logic [2:0]  oct_s2;
    always_ff @(posedge clk) begin
      x2_s1      <= x2_b[k];
      oct_s1     <= oct_b[k];
      x2_s2      <= x2_s1;
      oct_s2     <= oct_s1;
      x2_b[k+1]  <= x2_s2;
      oct_b[k+1] <= oct_s2;
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      localparam int DIV = (l == 0) ? (2 * k + 2) * (2 * k + 3) : (2 * k + 1) * (2 * k + 2);
      localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(DIV));
      localparam bit SUB = (k % 2) == 0;
      logic [60:0]        p_s1;
      logic signed [32:0] a_s1;
      logic signed [32:0] a_s2;
      logic [30:0]        n_s2;
      logic [30:0]        q0_s2;
      logic [62:0]        prod;
      logic [31:0]        rem;
      logic [30:0]        q;
      assign prod = 63'(p_s1[60:30]) * 63'(RECIP);
      assign rem  = 32'(n_s2) - 32'(q0_s2) * 32'(DIV);
      assign q    = q0_s2 + 31'(rem >= 32'(DIV));
      always_ff @(posedge clk) begin
        p_s1  <= 61'(t_b[l][k]) * 61'(x2_b[k]);
        a_s1  <= a_b[l][k];
        n_s2  <= p_s1[60:30];
        q0_s2 <= prod[62:32];
        a_s2  <= a_s1;
        t_b[l][k+1] <= q;
        if (SUB) a_b[l][k+1] <= a_s2 - $signed({2'b00, q});
        else     a_b[l][k+1] <= a_s2 + $signed({2'b00, q});
      end
    end
  end

  // Clamp, swap by octant and sign by quadrant
  always_comb begin
    s_cl = clamp_q30(a_b[0][TERMS]);
    c_cl = clamp_q30(a_b[1][TERMS]);
    sa   = oct_b[TERMS][0] ? c_cl : s_cl;
    ca   = oct_b[TERMS][0] ? s_cl : c_cl;
    case (oct_b[TERMS][2:1])
      2'd0: begin
        cos_next = '{neg: 1'b0, mag: ca};
        sin_next = '{neg: 1'b0, mag: sa};
      end
      2'd1: begin
        cos_next = '{neg: 1'b1, mag: sa};
        sin_next = '{neg: 1'b0, mag: ca};
      end
      2'd2: begin
        cos_next = '{neg: 1'b1, mag: ca};
        sin_next = '{neg: 1'b1, mag: sa};
      end
      default: begin
        cos_next = '{neg: 1'b0, mag: sa};
        sin_next = '{neg: 1'b1, mag: ca};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cos_out <= cos_next;
    sin_out <= sin_next;
  end

endmodule

// ===== sv/bmg_scale.sv =====
`timescale 1ns / 1ps
module bmg_scale import bmg_pkg::*; (
  input  logic               clk,
  input  logic [30:0]        r,
  input  trig_t              trig,
  input  logic signed [31:0] mean,
  input  logic [30:0]        std_dev,
  output logic signed [31:0] sample
);

  logic [61:0]        prod;
  logic               neg1;
  logic [61:0]        z_sum;
  logic [58:0]        zs;
  logic               neg2;
  logic [58:0]        d_sum;
  logic signed [36:0] sum;
  logic signed [31:0] sat;

  // Round r*trig to Z_FRAC, then scale by std_dev
  assign z_sum = prod + (62'd1 << (R_FRAC + TRIG_FRAC - Z_FRAC - 1));
  assign d_sum = zs + (59'd1 << (Z_FRAC - 1));

  // Add the mean and saturate
  always_comb begin
    if (neg2) sum = 37'(mean) - $signed({2'b00, d_sum[58:24]});
    else      sum = 37'(mean) + $signed({2'b00, d_sum[58:24]});
    if (sum > 37'sh0_7FFF_FFFF)       sat = 32'sh7FFF_FFFF;
    else if (sum < -37'sh0_8000_0000) sat = 32'sh8000_0000;
    else                              sat = sum[31:0];
  end

  always_ff @(posedge clk) begin
    prod   <= 62'(r) * 62'(trig.mag);
    neg1   <= trig.neg;
    zs     <= 59'(z_sum[61:34]) * 59'(std_dev);
    neg2   <= neg1;
    sample <= sat;
  end

endmodule

// ===== sv/box_muller_gaussian_pair.sv =====
`timescale 1ns / 1ps
// Box-Muller Gaussian pair generator.
// Pulse start with a uniform pair (uniform_u, uniform_v, Q0.32) and
// single_only; the beat is taken at a rising edge with start high and busy
// low. busy is high only while rst is asserted, so a new pair may enter on
// every cycle. A pair with u zero or |u - v| <= tolerance is dropped and
// gives no result. Each kept pair gives one result beat: done is high for
// one cycle with sample_first, sample_second and second_valid; throughput is
// one pair per cycle. The latency is set by the 30 log2 squaring stages, the
// 32 square-root stages and the final scaling multiplies. Results come out
// in order and cannot be held off by the receiver. Configuration (mean,
// std_dev, tolerance) is written through cfg_we/cfg_index/cfg_data; the user
// must do so only while no pair is in flight, as the block does not enforce
// it. A synchronous reset clears the pipeline valid bits and returns the
// registers to mean 0, std_dev 1.0 and tolerance 0.
module box_muller_gaussian_pair import bmg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        uniform_u,
  input  logic [31:0]        uniform_v,
  input  logic               single_only,
  output logic               done,
  output logic signed [31:0] sample_first,
  output logic signed [31:0] sample_second,
  output logic               second_valid,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic signed [31:0] mean;
  logic [30:0]        std_dev;
  logic [31:0]        tolerance;
  logic               accept;
  logic [31:0]        diff;
  logic               keep;
  logic               valid0;
  logic [31:0]        u0;
  logic [31:0]        v0;
  logic               single0;
  logic               vld_line [0:TOTAL_LAT-1];
  logic               sgl_line [0:TOTAL_LAT-1];
  logic [31:0]        v_line   [0:TRIG_DELAY-1];
  logic [35:0]        neg2ln;
  logic [30:0]        r;
  trig_t              cos_t;
  trig_t              sin_t;
  logic signed [31:0] first_s;
  logic signed [31:0] second_s;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mean      <= '0;
      std_dev   <= 31'd65536;
      tolerance <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_MEAN:      mean      <= $signed(cfg_data);
        REG_STD_DEV:   std_dev   <= cfg_data[30:0];
        REG_TOLERANCE: tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept and screen the input beat
  assign busy   = rst;
  assign accept = start && !busy;
  assign diff   = (uniform_u > uniform_v) ? (uniform_u - uniform_v) : (uniform_v - uniform_u);
  assign keep   = accept && (uniform_u != '0) && (diff > tolerance);

  always_ff @(posedge clk) begin
    if (rst) valid0 <= 1'b0;
    else     valid0 <= keep;
    u0      <= uniform_u;
    v0      <= uniform_v;
    single0 <= single_only;
  end

  // Carry valid and single flag alongside the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TOTAL_LAT; i++) vld_line[i] <= 1'b0;
    end else begin
      vld_line[0] <= valid0;
      for (int i = 1; i < TOTAL_LAT; i++) vld_line[i] <= vld_line[i-1];
    end
  end

  always_ff @(posedge clk) begin
    sgl_line[0] <= single0;
    for (int i = 1; i < TOTAL_LAT; i++) sgl_line[i] <= sgl_line[i-1];
    v_line[0] <= v0;
    for (int i = 1; i < TRIG_DELAY; i++) v_line[i] <= v_line[i-1];
  end

  bmg_log u_log (
    .clk    (clk),
    .u      (u0),
    .neg2ln (neg2ln)
  );

  bmg_sqrt u_sqrt (
    .clk  (clk),
    .x_in (neg2ln),
    .r    (r)
  );

  bmg_trig u_trig (
    .clk     (clk),
    .v       (v_line[TRIG_DELAY-1]),
    .cos_out (cos_t),
    .sin_out (sin_t)
  );

  bmg_scale u_scale_first (
    .clk     (clk),
    .r       (r),
    .trig    (cos_t),
    .mean    (mean),
    .std_dev (std_dev),
    .sample  (first_s)
  );

  bmg_scale u_scale_second (
    .clk     (clk),
    .r       (r),
    .trig    (sin_t),
    .mean    (mean),
    .std_dev (std_dev),
    .sample  (second_s)
  );

  // Result beat
  assign done          = vld_line[TOTAL_LAT-1];
  assign second_valid  = !sgl_line[TOTAL_LAT-1];
  assign sample_first  = first_s;
  assign sample_second = sgl_line[TOTAL_LAT-1] ? 32'sd0 : second_s;

`ifndef SYNTH
  // A result beat traces back to an earlier accepted input beat
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT + 1))
    else $error("result beat without a matching input beat");

  // A zero u never reaches the output
  a_zero_drop: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(uniform_u, TOTAL_LAT + 1) != '0))
    else $error("zero u produced a result");

  // Reset flushes the pipeline
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result beat right after reset");
`endif

endmodule
